/* rtl/sorted_stream_distinct_compactor_top_macros.svh */
// Assertion macros shared by the compactor RTL.
// Included by sdc_merge.sv and sorted_stream_distinct_compactor_top.sv; expects clk and rst_n.
`ifndef SORTED_STREAM_DISTINCT_COMPACTOR_TOP_MACROS_SVH
`define SORTED_STREAM_DISTINCT_COMPACTOR_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle property, checked on every clock edge out of reset.
`define SDC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sdc assertion failed");

// Next-cycle implication.
`define SDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdc assertion failed");

`else

`define SDC_ASSERT(label, prop)
`define SDC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/sdc_pkg.sv */
// Shared types and constants of the sorted stream distinct compactor.
// No dependencies; used by sdc_lane, sdc_merge and the top level.
`default_nettype none

package sdc_pkg;

    localparam int LANES  = 8;
    localparam int ELEM_W = 64;
    localparam int CNT_W  = 4;
    localparam int IDX_W  = (LANES > 1) ? $clog2(LANES) : 1;

    typedef logic signed [ELEM_W-1:0] elem_t;

    // Control that travels with a beat from the flag stage to the merge stage
    typedef struct packed {
        logic [LANES-1:0] keep;
        logic             eov;
    } sdc_beat_t;

endpackage

`default_nettype wire

/* rtl/sorted_stream_distinct_compactor_top.sv */
// Top level of the sorted stream distinct compactor: input flag stage with the
// carried predecessor, lane instances and the merge stage.
// Depends on sdc_pkg, sdc_lane, sdc_merge and the macro header.
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+---------------------------------------------
//   beat    | beat_valid   | beat_stall   | value_0..7, lane_count, end_of_vector
//   result  | result_valid | result_stall | kept_0..7, kept_count, vector_done
//
// One beat per cycle while result_stall stays low; a taken beat lands in the flag
// register and moves on to the result register as soon as the merge stage can
// take it, so a result stall holds it in the flag register.
// The carried predecessor is registered as each beat is taken (held across an
// empty beat, cleared at end of vector), so the lane compares of the next beat see it.
// Reset clears the pipeline valids and the carried predecessor.
// beat_stall rises only while both pipeline registers hold and result_stall is high.
`default_nettype none
`include "sorted_stream_distinct_compactor_top_macros.svh"

module sorted_stream_distinct_compactor_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      beat_valid,
    output logic                      beat_stall,
    input  sdc_pkg::elem_t            value_0,
    input  sdc_pkg::elem_t            value_1,
    input  sdc_pkg::elem_t            value_2,
    input  sdc_pkg::elem_t            value_3,
    input  sdc_pkg::elem_t            value_4,
    input  sdc_pkg::elem_t            value_5,
    input  sdc_pkg::elem_t            value_6,
    input  sdc_pkg::elem_t            value_7,
    input  logic [sdc_pkg::CNT_W-1:0] lane_count,
    input  logic                      end_of_vector,
    output logic                      result_valid,
    input  logic                      result_stall,
    output sdc_pkg::elem_t            kept_0,
    output sdc_pkg::elem_t            kept_1,
    output sdc_pkg::elem_t            kept_2,
    output sdc_pkg::elem_t            kept_3,
    output sdc_pkg::elem_t            kept_4,
    output sdc_pkg::elem_t            kept_5,
    output sdc_pkg::elem_t            kept_6,
    output sdc_pkg::elem_t            kept_7,
    output logic [sdc_pkg::CNT_W-1:0] kept_count,
    output logic                      vector_done
);
    import sdc_pkg::*;

    elem_t            vals [LANES];
    elem_t            kept [LANES];
    logic [CNT_W-1:0] eff_count;
    logic [IDX_W-1:0] last_idx;
    logic [LANES-1:0] keep;
    logic             beat_accept;
    logic             s1_take;
    logic             merge_hold;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    elem_t            s1_vals_reg [LANES];
    sdc_beat_t        s1_beat_reg;
    sdc_beat_t        s1_beat_next;

    elem_t            prev_value_reg;
    elem_t            prev_value_next;
    logic             have_prev_reg;
    logic             have_prev_next;

    assign vals[0] = value_0;
    assign vals[1] = value_1;
    assign vals[2] = value_2;
    assign vals[3] = value_3;
    assign vals[4] = value_4;
    assign vals[5] = value_5;
    assign vals[6] = value_6;
    assign vals[7] = value_7;

    // Saturate the lane count to the lane total
    assign eff_count = (lane_count > CNT_W'(LANES)) ? CNT_W'(LANES) : lane_count;
    assign last_idx  = IDX_W'(eff_count - CNT_W'(1));

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        if (i == 0)
        begin : g_first
            sdc_lane u_lane (
                .value   (vals[i]),
                .pred    (prev_value_reg),
                .pred_ok (have_prev_reg),
                .live    (eff_count > CNT_W'(i)),
                .keep    (keep[i])
            );
        end
        else
        begin : g_rest
            sdc_lane u_lane (
                .value   (vals[i]),
                .pred    (vals[i-1]),
                .pred_ok (1'b1),
                .live    (eff_count > CNT_W'(i)),
                .keep    (keep[i])
            );
        end
    end

    assign s1_take     = !s1_valid_reg || !merge_hold;
    assign beat_stall  = !s1_take;
    assign beat_accept = beat_valid && s1_take;

    assign s1_valid_next     = s1_take ? beat_valid : s1_valid_reg;
    assign s1_beat_next.keep = keep;
    assign s1_beat_next.eov  = end_of_vector;

    // Carry the last live element; drop it at the end of a vector
    always_comb
    begin
        prev_value_next = prev_value_reg;
        have_prev_next  = have_prev_reg;
        if (beat_accept)
        begin
            if (end_of_vector)
            begin
                prev_value_next = '0;
                have_prev_next  = 1'b0;
            end
            else if (eff_count != '0)
            begin
                prev_value_next = vals[last_idx];
                have_prev_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            prev_value_reg <= '0;
            have_prev_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            prev_value_reg <= prev_value_next;
            have_prev_reg  <= have_prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_accept)
        begin
            s1_vals_reg <= vals;
            s1_beat_reg <= s1_beat_next;
        end
    end

    sdc_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .beat_valid   (s1_valid_reg),
        .vals         (s1_vals_reg),
        .beat         (s1_beat_reg),
        .hold         (merge_hold),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kept         (kept),
        .kept_count   (kept_count),
        .vector_done  (vector_done)
    );

    assign kept_0 = kept[0];
    assign kept_1 = kept[1];
    assign kept_2 = kept[2];
    assign kept_3 = kept[3];
    assign kept_4 = kept[4];
    assign kept_5 = kept[5];
    assign kept_6 = kept[6];
    assign kept_7 = kept[7];

    `SDC_ASSERT_NEXT(a_eov_clears, beat_accept && end_of_vector, !have_prev_reg && (prev_value_reg == '0))
    `SDC_ASSERT_NEXT(a_carry_set, beat_accept && !end_of_vector && (lane_count != '0), have_prev_reg)
    `SDC_ASSERT_NEXT(a_first_kept, beat_accept && !have_prev_reg && (lane_count != '0), s1_beat_reg.keep[0])

endmodule

`default_nettype wire

/* rtl/sdc_lane.sv */
// One lane of the duplicate detector: flags a live element that starts a vector
// or differs from its predecessor. Depends on sdc_pkg.
`default_nettype none

module sdc_lane (
    input  sdc_pkg::elem_t value,
    input  sdc_pkg::elem_t pred,
    input  logic           pred_ok,
    input  logic           live,
    output logic           keep
);
    import sdc_pkg::*;

    assign keep = live && (!pred_ok || (value != pred));

endmodule

`default_nettype wire

/* rtl/sdc_merge.sv */
// Merge stage: prefix sum of the lane keep flags, dense packing of kept
// elements and the result register. Depends on sdc_pkg and the macro header.
`default_nettype none
`include "sorted_stream_distinct_compactor_top_macros.svh"

module sdc_merge (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               beat_valid,
    input  sdc_pkg::elem_t     vals [sdc_pkg::LANES],
    input  sdc_pkg::sdc_beat_t beat,
    output logic               hold,
    output logic               result_valid,
    input  logic               result_stall,
    output sdc_pkg::elem_t     kept [sdc_pkg::LANES],
    output logic [sdc_pkg::CNT_W-1:0] kept_count,
    output logic               vector_done
);
    import sdc_pkg::*;

    logic                  take;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    elem_t                 kept_reg  [LANES];
    elem_t                 kept_next [LANES];
    logic [CNT_W-1:0]      kept_count_reg;
    logic [CNT_W-1:0]      kept_count_next;
    logic                  done_reg;
    logic [CNT_W-1:0]      pos [LANES];

    // Output register frees up whenever it is empty or being drained
    assign take = !out_valid_reg || !result_stall;
    assign hold = !take;

    always_comb
    begin
        logic [CNT_W-1:0] running;
        running = '0;
        for (int i = 0; i < LANES; i++)
        begin
            pos[i]  = running;
            running = running + CNT_W'(beat.keep[i]);
        end
        kept_count_next = running;
        for (int j = 0; j < LANES; j++)
        begin
            kept_next[j] = '0;
            for (int i = 0; i < LANES; i++)
            begin
                if (beat.keep[i] && (pos[i] == CNT_W'(j)))
                begin
                    kept_next[j] = kept_next[j] | vals[i];
                end
            end
        end
    end

    assign out_valid_next = take ? beat_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && beat_valid)
        begin
            kept_reg       <= kept_next;
            kept_count_reg <= kept_count_next;
            done_reg       <= beat.eov;
        end
    end

    assign result_valid = out_valid_reg;
    assign kept         = kept_reg;
    assign kept_count   = kept_count_reg;
    assign vector_done  = done_reg;

    `SDC_ASSERT(a_count_range, !out_valid_reg || (kept_count_reg <= CNT_W'(LANES)))
    `SDC_ASSERT(a_pad_zero, !out_valid_reg || (kept_count_reg == CNT_W'(LANES)) || (kept_reg[LANES-1] == '0))
    `SDC_ASSERT_NEXT(a_count_matches, take && beat_valid, kept_count_reg == CNT_W'($countones($past(beat.keep))))

endmodule

`default_nettype wire

/* tb/sdc_distinct_checker.sv */
`timescale 1ns / 1ps
// Checker for the sorted stream distinct compactor: watches the beat and result channels,
// predicts each result from the accepted beats and compares it lane by lane. Uses sdc_pkg.
`default_nettype none

module sdc_distinct_checker
    import sdc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 beat_valid,
    input  logic                 beat_stall,
    input  elem_t                value_0,
    input  elem_t                value_1,
    input  elem_t                value_2,
    input  elem_t                value_3,
    input  elem_t                value_4,
    input  elem_t                value_5,
    input  elem_t                value_6,
    input  elem_t                value_7,
    input  logic [CNT_W-1:0]     lane_count,
    input  logic                 end_of_vector,
    input  logic                 result_valid,
    input  logic                 result_stall,
    input  elem_t                kept_0,
    input  elem_t                kept_1,
    input  elem_t                kept_2,
    input  elem_t                kept_3,
    input  elem_t                kept_4,
    input  elem_t                kept_5,
    input  elem_t                kept_6,
    input  elem_t                kept_7,
    input  logic [CNT_W-1:0]     kept_count,
    input  logic                 vector_done,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [LANES-1:0][ELEM_W-1:0] kept;
        logic [CNT_W-1:0]             count;
        logic                         done;
    } compacted_t;

    compacted_t              expected_q[$];
    logic [ELEM_W-1:0]       carry_value;
    logic                    carry_valid;
    int                      mismatches = 0;

    logic [LANES-1:0][ELEM_W-1:0] beat_lanes;
    logic [LANES-1:0][ELEM_W-1:0] result_lanes;

    assign beat_lanes   = {value_7, value_6, value_5, value_4,
                           value_3, value_2, value_1, value_0};
    assign result_lanes = {kept_7, kept_6, kept_5, kept_4,
                           kept_3, kept_2, kept_1, kept_0};
    assign fail_count   = mismatches;

    // Drop repeats of the carried or in-beat predecessor and pack the survivors from lane 0.
    function automatic compacted_t compact_beat(input logic [LANES-1:0][ELEM_W-1:0] vals,
                                                input logic [CNT_W-1:0] cnt,
                                                input logic eov);
        compacted_t r;
        int         n;
        int         pos;
        r   = '0;
        pos = 0;
        n   = (int'(cnt) > LANES) ? LANES : int'(cnt);
        for (int i = 0; i < n; i++)
        begin
            if (!carry_valid || vals[i] != carry_value)
            begin
                r.kept[pos] = vals[i];
                pos++;
            end
            carry_value = vals[i];
            carry_valid = 1'b1;
        end
        r.count = CNT_W'(pos);
        r.done  = eov;
        if (eov)
        begin
            carry_value = '0;
            carry_valid = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [ELEM_W-1:0] got,
                                   input logic [ELEM_W-1:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        compacted_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            carry_value = '0;
            carry_valid = 1'b0;
            pending    <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("result with no transaction pending", 64'(kept_count), '0);
                end
                else
                begin
                    want = expected_q.pop_front();
                    for (int j = 0; j < LANES; j++)
                    begin
                        if (result_lanes[j] !== want.kept[j])
                            report_mismatch($sformatf("kept_%0d", j), result_lanes[j],
                                            want.kept[j]);
                    end
                    if (kept_count !== want.count)
                        report_mismatch("kept_count", 64'(kept_count), 64'(want.count));
                    if (vector_done !== want.done)
                        report_mismatch("vector_done", 64'(vector_done), 64'(want.done));
                end
            end
            if (beat_valid && !beat_stall)
                expected_q.push_back(compact_beat(beat_lanes, lane_count, end_of_vector));
            pending <= expected_q.size();
        end
    end

endmodule

`default_nettype wire

/* tb/tb_sorted_stream_distinct_compactor_top.sv */
`timescale 1ns / 1ps
// Testbench top for the sorted stream distinct compactor: clock, reset, beat stimulus and
// random result stalls. Depends on sdc_pkg, the compactor RTL and sdc_distinct_checker.
`default_nettype none

module tb_sorted_stream_distinct_compactor_top;
    import sdc_pkg::*;

    localparam int RANDOM_BEATS = 1950;
    localparam int QUIET_BEATS  = 150;

    logic             clk;
    logic             rst_n;
    logic             beat_valid;
    logic             beat_stall;
    elem_t            value_0, value_1, value_2, value_3;
    elem_t            value_4, value_5, value_6, value_7;
    logic [CNT_W-1:0] lane_count;
    logic             end_of_vector;
    logic             result_valid;
    logic             result_stall;
    elem_t            kept_0, kept_1, kept_2, kept_3;
    elem_t            kept_4, kept_5, kept_6, kept_7;
    logic [CNT_W-1:0] kept_count;
    logic             vector_done;
    int               fail_count;
    int               pending;

    logic [LANES-1:0][ELEM_W-1:0] lanes_buf;
    logic             quiet;
    logic             sender_idles;
    int               beats_sent;

    sorted_stream_distinct_compactor_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .beat_valid    (beat_valid),
        .beat_stall    (beat_stall),
        .value_0       (value_0),
        .value_1       (value_1),
        .value_2       (value_2),
        .value_3       (value_3),
        .value_4       (value_4),
        .value_5       (value_5),
        .value_6       (value_6),
        .value_7       (value_7),
        .lane_count    (lane_count),
        .end_of_vector (end_of_vector),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .kept_0        (kept_0),
        .kept_1        (kept_1),
        .kept_2        (kept_2),
        .kept_3        (kept_3),
        .kept_4        (kept_4),
        .kept_5        (kept_5),
        .kept_6        (kept_6),
        .kept_7        (kept_7),
        .kept_count    (kept_count),
        .vector_done   (vector_done)
    );

    sdc_distinct_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .beat_valid    (beat_valid),
        .beat_stall    (beat_stall),
        .value_0       (value_0),
        .value_1       (value_1),
        .value_2       (value_2),
        .value_3       (value_3),
        .value_4       (value_4),
        .value_5       (value_5),
        .value_6       (value_6),
        .value_7       (value_7),
        .lane_count    (lane_count),
        .end_of_vector (end_of_vector),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .kept_0        (kept_0),
        .kept_1        (kept_1),
        .kept_2        (kept_2),
        .kept_3        (kept_3),
        .kept_4        (kept_4),
        .kept_5        (kept_5),
        .kept_6        (kept_6),
        .kept_7        (kept_7),
        .kept_count    (kept_count),
        .vector_done   (vector_done),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[sorted_stream_distinct_compactor_top] ERROR");
        $finish;
    end

    function automatic elem_t random_elem();
        return elem_t'({$urandom, $urandom});
    endfunction

    // Drive one transaction from lanes_buf and hold it until taken.
    task automatic send_beat(input logic [CNT_W-1:0] cnt, input logic eov);
        if (!quiet && sender_idles && $urandom_range(0, 5) == 0)
        begin
            beat_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        beat_valid    <= 1'b1;
        value_0       <= lanes_buf[0];
        value_1       <= lanes_buf[1];
        value_2       <= lanes_buf[2];
        value_3       <= lanes_buf[3];
        value_4       <= lanes_buf[4];
        value_5       <= lanes_buf[5];
        value_6       <= lanes_buf[6];
        value_7       <= lanes_buf[7];
        lane_count    <= cnt;
        end_of_vector <= eov;
        @(posedge clk);
        while (beat_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_direct(input elem_t v0, input elem_t v1, input elem_t v2,
                               input elem_t v3, input elem_t v4, input elem_t v5,
                               input elem_t v6, input elem_t v7,
                               input logic [CNT_W-1:0] cnt, input logic eov);
        lanes_buf = {v7, v6, v5, v4, v3, v2, v1, v0};
        send_beat(cnt, eov);
    endtask

    // Sorted vector with runs that span beats; now and then an odd lane count.
    task automatic send_sorted_vector(input int nbeats);
        elem_t            cur;
        int               r;
        logic [CNT_W-1:0] cnt;
        if ($urandom_range(0, 1) == 0)
            cur = random_elem();
        else
            cur = elem_t'($signed($urandom_range(0, 200)) - 100);
        for (int b = 0; b < nbeats; b++)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                r = $urandom_range(0, 19);
                if (r >= 17)
                    cur = cur + elem_t'($urandom);
                else if (r >= 10)
                    cur = cur + elem_t'($urandom_range(1, 3));
                lanes_buf[i] = cur;
            end
            r = $urandom_range(0, 19);
            if (r == 0)
                cnt = '0;
            else if (r == 1)
                cnt = CNT_W'($urandom_range(9, 15));
            else
                cnt = CNT_W'($urandom_range(1, LANES));
            send_beat(cnt, b == nbeats - 1);
        end
    endtask

    // Unsorted beat: random lanes with some repeats, any lane count, any marker.
    task automatic send_noise_beat();
        for (int i = 0; i < LANES; i++)
        begin
            if (i > 0 && $urandom_range(0, 2) == 0)
                lanes_buf[i] = lanes_buf[i-1];
            else
                lanes_buf[i] = random_elem();
        end
        send_beat(CNT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endtask

    // Receiver stalls in bursts, with run stretches of varying length in between.
    initial
    begin
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (quiet)
            begin
                result_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                if ($urandom_range(0, 7) != 0)
                begin
                    result_stall <= 1'b1;
                    repeat ($urandom_range(1, 19)) @(posedge clk);
                end
                result_stall <= 1'b0;
                repeat ($urandom_range(1, 80)) @(posedge clk);
            end
        end
    end

    initial
    begin
        elem_t mn;
        elem_t mx;
        mn            = {1'b1, {(ELEM_W-1){1'b0}}};
        mx            = {1'b0, {(ELEM_W-1){1'b1}}};
        quiet         = 1'b0;
        sender_idles  = 1'b1;
        beats_sent    = 0;
        lanes_buf     = '0;
        rst_n         <= 1'b0;
        beat_valid    <= 1'b0;
        value_0       <= '0;
        value_1       <= '0;
        value_2       <= '0;
        value_3       <= '0;
        value_4       <= '0;
        value_5       <= '0;
        value_6       <= '0;
        value_7       <= '0;
        lane_count    <= '0;
        end_of_vector <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First element after reset is kept even though it equals the cleared carry.
        send_direct(0, 0, 0, 0, 0, 0, 0, 0, 8, 1'b0);
        // Run continues across the beat boundary.
        send_direct(0, 0, 0, 0, 0, 0, 0, 0, 8, 1'b0);
        send_direct(mn, 0, 0, 0, 0, 0, 0, 0, 1, 1'b1);
        send_direct(mn, mn, -1, 0, 1, mx, mx, mx, 8, 1'b0);
        send_direct(mx, mx, mx, 0, 0, 0, 0, 0, 3, 1'b1);
        // New vector: the value that closed the last vector is kept again.
        send_direct(mx, 0, 0, 0, 0, 0, 0, 0, 1, 1'b0);
        // Empty beat holds the carry.
        send_direct(5, 6, 7, 8, 9, 10, 11, 12, 0, 1'b0);
        send_direct(mx, 0, 0, 0, 0, 0, 0, 0, 1, 1'b0);
        // Empty beat that still closes the vector.
        send_direct(mx, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        send_direct(mx, 0, 0, 0, 0, 0, 0, 0, 1, 1'b0);
        // Lane counts above the lane total saturate.
        send_direct(-3, -2, -1, 0, 1, 2, 3, 4, 9, 1'b0);
        send_direct(5, 6, 7, 8, 9, 10, 11, 12, 15, 1'b1);
        // Unsorted data: only neighbors are compared.
        send_direct(5, 3, 5, 5, 1, 9, 9, 2, 8, 1'b1);
        // Lanes past lane_count must not leak into the result.
        send_direct(1, 1, 2, 2, mx, mn, -1, 77, 4, 1'b1);
        send_direct(elem_t'(64'hAAAA_AAAA_AAAA_AAAA), elem_t'(64'h5555_5555_5555_5555),
                    elem_t'(64'hAAAA_AAAA_AAAA_AAAA), elem_t'(64'h5555_5555_5555_5555),
                    -1, -1, 0, 0, 7, 1'b1);
        send_direct(mx, mx, mx, mx, mx, mx, mx, mx, 8, 1'b0);
        send_direct(mx, mx, mx, mx, mx, mx, mx, mx, 8, 1'b1);
        send_direct(mn, mn, mn, mn, mn, mn, mn, mn, 12, 1'b1);

        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS)
        begin
            if (beats_sent % 64 == 0)
                sender_idles = ($urandom_range(0, 3) != 0);
            if (beats_sent >= RANDOM_BEATS - QUIET_BEATS)
                quiet = 1'b1;
            if ($urandom_range(0, 6) == 0)
                send_noise_beat();
            else
                send_sorted_vector($urandom_range(1, 6));
        end
        beat_valid <= 1'b0;
        quiet = 1'b1;

        // Let the checker see the last transaction before polling its backlog.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("[sorted_stream_distinct_compactor_top] OK");
        else
            $display("[sorted_stream_distinct_compactor_top] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
